/* rtl/quaternion_to_euler_zyx_assert.svh */
// Assertion macros for the quaternion to ZYX Euler angle block.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef QUATERNION_TO_EULER_ZYX_ASSERT_SVH
`define QUATERNION_TO_EULER_ZYX_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define Q2E_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2e check failed");
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q2e check failed");
`else
`define Q2E_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/q2e_pkg.sv */
// Shared types, widths and the arctangent table for the quaternion to Euler block.
// No dependencies.
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int SUM_W     = 34;            // 2*(ab + cd) of Q2.14 terms, Q.28
  localparam int MAG_W     = 28;            // |sin pitch| below one
  localparam int REM_W     = 2 * MAG_W + 1; // 2^56 - s^2
  localparam int SQRT_BITS = MAG_W + 1;     // floor root, up to 2^28
  localparam int CW        = 36;            // CORDIC vector width

  localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) << 28;

  // atan(2^-i) in Q.30, truncated
  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [SUM_W-1:0] sinr;
    logic signed [SUM_W-1:0] cosr;
    logic signed [SUM_W-1:0] sinp;
    logic signed [SUM_W-1:0] siny;
    logic signed [SUM_W-1:0] cosy;
    logic                    clamp;
  } side_t;

  // Table entry rounded half up to frac fraction bits
  function automatic logic [32:0] atan_round(input int idx, input int frac);
    logic [32:0] t;
    t = {1'b0, ATAN_Q30[idx]} + (33'd1 << (29 - frac));
    return t >> (30 - frac);
  endfunction

endpackage

/* rtl/q2e_front.sv */
// Front end: products, the five sums, clamp detect and 1 - s^2 for pitch.
// Three register stages; uses q2e_pkg.
`timescale 1ns / 1ps
module q2e_front
  import q2e_pkg::*;
(
  input  logic                    clk,
  input  logic [2:0]              en,
  input  logic signed [15:0]      quat_w,
  input  logic signed [15:0]      quat_x,
  input  logic signed [15:0]      quat_y,
  input  logic signed [15:0]      quat_z,
  output logic [REM_W-1:0]        rem_o,
  output side_t                   side_o
);

  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wy_r;
  logic signed [31:0] p_zx_r, p_wz_r, p_xy_r, p_zz_r;
  side_t              side_b_nxt, side_b_r, side_c_r;
  logic signed [SUM_W-1:0] mag;
  logic [MAG_W-1:0]   mag_b_nxt, mag_b_r;
  logic [2*MAG_W-1:0] m2;
  logic [REM_W-1:0]   rem_nxt, rem_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_wx_r <= quat_w * quat_x;
      p_yz_r <= quat_y * quat_z;
      p_xx_r <= quat_x * quat_x;
      p_yy_r <= quat_y * quat_y;
      p_wy_r <= quat_w * quat_y;
      p_zx_r <= quat_z * quat_x;
      p_wz_r <= quat_w * quat_z;
      p_xy_r <= quat_x * quat_y;
      p_zz_r <= quat_z * quat_z;
    end
  end

  always_comb begin
    side_b_nxt.sinr = (SUM_W'(p_wx_r) + SUM_W'(p_yz_r)) <<< 1;
    side_b_nxt.cosr = ONE_Q28 - ((SUM_W'(p_xx_r) + SUM_W'(p_yy_r)) <<< 1);
    side_b_nxt.sinp = (SUM_W'(p_wy_r) - SUM_W'(p_zx_r)) <<< 1;
    side_b_nxt.siny = (SUM_W'(p_wz_r) + SUM_W'(p_xy_r)) <<< 1;
    side_b_nxt.cosy = ONE_Q28 - ((SUM_W'(p_yy_r) + SUM_W'(p_zz_r)) <<< 1);
    mag = side_b_nxt.sinp[SUM_W-1] ? -side_b_nxt.sinp : side_b_nxt.sinp;
    side_b_nxt.clamp = (mag >= ONE_Q28);
    mag_b_nxt = mag[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_b_r <= side_b_nxt;
      mag_b_r  <= mag_b_nxt;
    end
  end

  // Root argument; meaningless when clamped, pitch is overridden then
  always_comb begin
    m2      = mag_b_r * mag_b_r;
    rem_nxt = (REM_W'(1) << (2 * MAG_W)) - REM_W'(m2);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_r    <= rem_nxt;
      side_c_r <= side_b_r;
    end
  end

  assign rem_o  = rem_r;
  assign side_o = side_c_r;

endmodule

/* rtl/q2e_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per stage.
// Carries the angle sums alongside; uses q2e_pkg.
`timescale 1ns / 1ps
module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int BIT = 0
)
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [REM_W-1:0]     rm_i,
  input  logic [SQRT_BITS-1:0] q_i,
  input  side_t                side_i,
  output logic [REM_W-1:0]     rm_o,
  output logic [SQRT_BITS-1:0] q_o,
  output side_t                side_o
);

  logic [REM_W-1:0]     trial;
  logic                 take;
  logic [REM_W-1:0]     rm_nxt, rm_r;
  logic [SQRT_BITS-1:0] q_nxt, q_r;
  side_t                side_r;

  // (q + 2^b)^2 - q^2 = q * 2^(b+1) + 2^(2b)
  always_comb begin
    trial  = (REM_W'(q_i) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
    take   = (rm_i >= trial);
    rm_nxt = take ? rm_i - trial : rm_i;
    q_nxt  = take ? (q_i | (SQRT_BITS'(1) << BIT)) : q_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r   <= rm_nxt;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign rm_o   = rm_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

/* rtl/q2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation for one lane, registered.
// Angle table from q2e_pkg.
`timescale 1ns / 1ps
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int STAGE      = 0,
  parameter int ANGLE_BITS = 16
)
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CW-1:0]    x_i,
  input  logic signed [CW-1:0]    y_i,
  input  logic signed [ANGLE_BITS:0] z_i,
  input  logic                    zero_i,
  output logic signed [CW-1:0]    x_o,
  output logic signed [CW-1:0]    y_o,
  output logic signed [ANGLE_BITS:0] z_o,
  output logic                    zero_o
);

  localparam int FRAC = ANGLE_BITS - 3;
  localparam int ZW   = ANGLE_BITS + 1;
  localparam logic signed [ZW-1:0] ENTRY = ZW'(atan_round(STAGE, FRAC));

  logic signed [CW-1:0] dx, dy, x_nxt, y_nxt, x_r, y_r;
  logic signed [ZW-1:0] z_nxt, z_r;
  logic                 pos, zero_r;

  always_comb begin
    dx  = y_i >>> STAGE;
    dy  = x_i >>> STAGE;
    pos = !y_i[CW-1] && (y_i != '0);
    if (pos) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ENTRY;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ENTRY;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign zero_o = zero_r;

endmodule

/* rtl/quaternion_to_euler_zyx.sv */
// Quaternion to ZYX Euler angles: top level with stream handshake and pipeline control.
// Uses q2e_pkg, q2e_front, q2e_sqrt_cell, q2e_cordic_cell and the assertion header.
//
// Takes one quaternion per clock while out_tready is high and returns roll, pitch and
// yaw in Q3.13 radians through three front stages (products, sums, 1 - s^2), a
// 29-cell square root chain for the pitch cosine, one quadrant stage, CORDIC_STAGES
// micro-rotation cells running three lanes side by side, and the output register.
// Every cell moves its word on when the next one is free, so empty slots fill up
// under back-pressure and in_tready stays high as long as any slot is empty.
// pitch_clamped in out_tuser flags gimbal lock; pitch is then forced to plus or
// minus pi/2, as rounded from the arctangent table.
`timescale 1ns / 1ps
`include "quaternion_to_euler_zyx_assert.svh"
module quaternion_to_euler_zyx
  import q2e_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic        out_tuser   // pitch_clamped
);

  localparam int FRAC = ANGLE_BITS - 3;
  localparam int ZW   = ANGLE_BITS + 1;
  localparam int VW   = ZW + 14;
  localparam int SQ0  = 3;
  localparam int PRE  = SQ0 + SQRT_BITS;
  localparam int CD0  = PRE + 1;
  localparam int OUTS = CD0 + CORDIC_STAGES;
  localparam int NS   = OUTS + 1;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(atan_round(0, FRAC) << 1);

  typedef struct packed {
    logic clamp;
    logic neg;
  } pflag_t;

  logic [NS-1:0] v_r, en;

  // A stage loads when it is empty or every stage after it can move
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_tready | ~(&v_r[NS-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  // Front end
  logic [REM_W-1:0]     sq_rm   [SQRT_BITS+1];
  logic [SQRT_BITS-1:0] sq_q    [SQRT_BITS+1];
  side_t                sq_side [SQRT_BITS+1];

  q2e_front u_front (
    .clk    (clk),
    .en     (en[2:0]),
    .quat_w (in_tdata[15:0]),
    .quat_x (in_tdata[31:16]),
    .quat_y (in_tdata[47:32]),
    .quat_z (in_tdata[63:48]),
    .rem_o  (sq_rm[0]),
    .side_o (sq_side[0])
  );

  assign sq_q[0] = '0;

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    q2e_sqrt_cell #(.BIT(SQRT_BITS - 1 - j)) u_cell (
      .clk    (clk),
      .en     (en[SQ0+j]),
      .rm_i   (sq_rm[j]),
      .q_i    (sq_q[j]),
      .side_i (sq_side[j]),
      .rm_o   (sq_rm[j+1]),
      .q_o    (sq_q[j+1]),
      .side_o (sq_side[j+1])
    );
  end

  // Quadrant stage: fold a negative cosine into the right half plane
  logic signed [CW-1:0] pin_x [3], pin_y [3];
  logic signed [CW-1:0] pre_x_r [3], pre_y_r [3];
  logic signed [ZW-1:0] pre_z_r [3];
  logic                 pre_zero_r [3];
  pflag_t               pf_r [CORDIC_STAGES+1];
  side_t                sd;

  always_comb begin
    sd = sq_side[SQRT_BITS];
    pin_y[LANE_ROLL]  = CW'(sd.sinr);
    pin_x[LANE_ROLL]  = CW'(sd.cosr);
    pin_y[LANE_PITCH] = CW'(sd.sinp);
    pin_x[LANE_PITCH] = {{(CW-SQRT_BITS){1'b0}}, sq_q[SQRT_BITS]};
    pin_y[LANE_YAW]   = CW'(sd.siny);
    pin_x[LANE_YAW]   = CW'(sd.cosy);
  end

  always_ff @(posedge clk) begin
    if (en[PRE]) begin
      for (int l = 0; l < 3; l++) begin
        pre_zero_r[l] <= (pin_y[l] == '0) && !pin_x[l][CW-1];
        if (pin_x[l][CW-1]) begin
          if (!pin_y[l][CW-1]) begin
            pre_x_r[l] <= pin_y[l];
            pre_y_r[l] <= -pin_x[l];
            pre_z_r[l] <= HALF_PI;
          end else begin
            pre_x_r[l] <= -pin_y[l];
            pre_y_r[l] <= pin_x[l];
            pre_z_r[l] <= -HALF_PI;
          end
        end else begin
          pre_x_r[l] <= pin_x[l];
          pre_y_r[l] <= pin_y[l];
          pre_z_r[l] <= '0;
        end
      end
    end
  end

  // CORDIC chain, three lanes
  logic signed [CW-1:0] cx [CORDIC_STAGES+1][3];
  logic signed [CW-1:0] cy [CORDIC_STAGES+1][3];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1][3];
  logic                 cn [CORDIC_STAGES+1][3];

  for (genvar l = 0; l < 3; l++) begin : g_lane_in
    assign cx[0][l] = pre_x_r[l];
    assign cy[0][l] = pre_y_r[l];
    assign cz[0][l] = pre_z_r[l];
    assign cn[0][l] = pre_zero_r[l];
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    for (genvar l = 0; l < 3; l++) begin : g_lane
      q2e_cordic_cell #(.STAGE(i), .ANGLE_BITS(ANGLE_BITS)) u_cell (
        .clk    (clk),
        .en     (en[CD0+i]),
        .x_i    (cx[i][l]),
        .y_i    (cy[i][l]),
        .z_i    (cz[i][l]),
        .zero_i (cn[i][l]),
        .x_o    (cx[i+1][l]),
        .y_o    (cy[i+1][l]),
        .z_o    (cz[i+1][l]),
        .zero_o (cn[i+1][l])
      );
    end
  end

  // Pitch flags ride alongside the rotation cells
  always_ff @(posedge clk) begin
    if (en[PRE]) pf_r[0] <= '{clamp: sd.clamp, neg: sd.sinp[SUM_W-1]};
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (en[CD0+i]) pf_r[i+1] <= pf_r[i];
    end
  end

  // Output stage: special cases, rounding to Q3.13, saturation
  logic signed [ZW-1:0] fin_a [3];
  logic [15:0]          ang_nxt [3];
  logic [15:0]          out_ang_r [3];
  logic                 out_clamp_r;
  pflag_t               pf_end;

  always_comb begin
    pf_end = pf_r[CORDIC_STAGES];
    for (int l = 0; l < 3; l++) begin
      fin_a[l] = cn[CORDIC_STAGES][l] ? '0 : cz[CORDIC_STAGES][l];
    end
    if (pf_end.clamp) begin
      fin_a[LANE_PITCH] = pf_end.neg ? -HALF_PI : HALF_PI;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    localparam logic signed [VW-1:0] SAT_HI = VW'(32767);
    localparam logic signed [VW-1:0] SAT_LO = VW'(-32768);
    logic signed [VW-1:0] av, vv;
    assign av = VW'(fin_a[l]);
    if (FRAC > 13) begin : g_rnd
      localparam logic signed [VW-1:0] HALF = {{(VW-1){1'b0}}, 1'b1} << (FRAC - 14);
      assign vv = (av + HALF) >>> (FRAC - 13);
    end else begin : g_scl
      assign vv = av <<< (13 - FRAC);
    end
    always_comb begin
      if (vv > SAT_HI) begin
        ang_nxt[l] = 16'h7FFF;
      end else if (vv < SAT_LO) begin
        ang_nxt[l] = 16'h8000;
      end else begin
        ang_nxt[l] = vv[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      for (int l = 0; l < 3; l++) out_ang_r[l] <= ang_nxt[l];
      out_clamp_r <= pf_end.clamp;
    end
  end

  assign out_tdata = {out_ang_r[LANE_YAW], out_ang_r[LANE_PITCH], out_ang_r[LANE_ROLL]};
  assign out_tuser = out_clamp_r;

  logic pitch_lock_ok;
  assign pitch_lock_ok = (out_tdata[31:28] == 4'h3) || (out_tdata[31:28] == 4'hC);

  // An empty output slot frees the whole chain
  `Q2E_ASSERT_IMPL(a_empty_out_ready, clk, rst_n, !out_tvalid, in_tready)
  // An accepted word lands in the first stage
  `Q2E_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_tvalid && in_tready, v_r[0])
  // Gimbal lock gives pitch of about plus or minus pi/2
  `Q2E_ASSERT_IMPL(a_clamp_pitch, clk, rst_n, out_tvalid && out_tuser, pitch_lock_ok)

endmodule

/* bench/tb_quaternion_to_euler_zyx.sv */
// Self-checking bench for quaternion_to_euler_zyx: streams quaternions in, checks each
// roll/pitch/yaw word against a bit-exact CORDIC predictor under random flow control.
// Depends on q2e_pkg (arctangent table) and the quaternion_to_euler_zyx RTL.
`timescale 1ns / 1ps
module tb_quaternion_to_euler_zyx
  import q2e_pkg::*;
;
  localparam int     CORDIC_STAGES = 16;
  localparam int     ANGLE_BITS    = 16;
  localparam int     FRAC          = ANGLE_BITS - 3;
  localparam int     RANDOM_ITEMS  = 1100;
  localparam int     DRAIN_CYCLES  = 60;
  localparam int     CYCLE_LIMIT   = 200000;
  localparam longint UNIT_Q28      = 64'sd1 <<< 28;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  logic [63:0] quat_queue[$];
  euler_t      expected_angles[$];
  int          errors = 0;
  int          in_accepts = 0;
  int          accepts_seen = 0;
  bit          busy = 1'b0;
  logic [63:0] cur_quat = '0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_cycle = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          cycle_count = 0;

  quaternion_to_euler_zyx #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .ANGLE_BITS   (ANGLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // quat_w, quat_x, quat_y, quat_z
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // roll_angle, pitch_angle, yaw_angle
    .out_tuser (out_tuser)   // pitch_clamped
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // atan(2^-i) rounded half up to the accumulator precision
  function automatic longint atan_step(int i);
    longint unsigned t;
    if (i >= 24) return 0;
    t = ATAN_Q30[i];
    return longint'((t + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  function automatic longint vector_angle(longint sy, longint sx);
    longint ax, ay, az, t, dx, dy;
    int     n;
    ax = sx;
    ay = sy;
    az = 0;
    n  = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    if (ay == 0 && ax >= 0) return 0;
    // turn left-half vectors into the right half first
    if (ax < 0) begin
      t = ax;
      if (ay >= 0) begin
        ax = ay;
        ay = -t;
        az = 2 * atan_step(0);
      end else begin
        ax = -ay;
        ay = t;
        az = -2 * atan_step(0);
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = ay >>> i;
      dy = ax >>> i;
      if (ay > 0) begin
        ax += dx;
        ay -= dy;
        az += atan_step(i);
      end else begin
        ax -= dx;
        ay += dy;
        az -= atan_step(i);
      end
    end
    return az;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] to_q313(longint a);
    longint v;
    if (FRAC > 13) v = (a + (longint'(1) << (FRAC - 14))) >>> (FRAC - 13);
    else v = a * (longint'(1) << (13 - FRAC));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic euler_t euler_of(logic [63:0] word);
    longint          w, x, y, z, sinr, cosr, sinp, siny, cosy, mag, pitch;
    longint unsigned rem;
    euler_t          e;
    w    = longint'($signed(word[15:0]));
    x    = longint'($signed(word[31:16]));
    y    = longint'($signed(word[47:32]));
    z    = longint'($signed(word[63:48]));
    sinr = 2 * (w * x + y * z);
    cosr = UNIT_Q28 - 2 * (x * x + y * y);
    sinp = 2 * (w * y - z * x);
    siny = 2 * (w * z + x * y);
    cosy = UNIT_Q28 - 2 * (y * y + z * z);
    mag  = (sinp < 0) ? -sinp : sinp;
    e.clamped = (mag >= UNIT_Q28);
    // gimbal lock: pin pitch to +-pi/2
    if (e.clamped) begin
      pitch = 2 * atan_step(0);
      if (sinp < 0) pitch = -pitch;
    end else begin
      rem   = (64'd1 << 56) - longint'(mag) * longint'(mag);
      pitch = vector_angle(sinp, longint'(root_floor(rem)));
    end
    e.roll  = to_q313(vector_angle(sinr, cosr));
    e.pitch = to_q313(pitch);
    e.yaw   = to_q313(vector_angle(siny, cosy));
    return e;
  endfunction

  function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  function automatic logic [63:0] unit_quat();
    real         c[4];
    real         n;
    logic [63:0] wd;
    n = 0.0;
    for (int k = 0; k < 4; k++) begin
      c[k] = $itor($urandom_range(0, 32768)) - 16384.0;
      n += c[k] * c[k];
    end
    if (n < 1.0) return pack_quat(16384, 0, 0, 0);
    n = $sqrt(n);
    for (int k = 0; k < 4; k++) wd[16*k +: 16] = 16'($rtoi(c[k] * 16384.0 / n));
    return wd;
  endfunction

  // pitch argument close to +-1, from either the w*y or the z*x product
  function automatic logic [63:0] near_lock();
    int a, b, p, q;
    a = 11585 + int'($urandom_range(0, 6)) - 3;
    b = 11585 + int'($urandom_range(0, 6)) - 3;
    p = int'($urandom_range(0, 8)) - 4;
    q = int'($urandom_range(0, 8)) - 4;
    if ($urandom_range(0, 1)) b = -b;
    if ($urandom_range(0, 1)) return pack_quat(a, p, b, q);
    return pack_quat(p, -b, q, a);
  endfunction

  // input side: predict every accepted word
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_angles.push_back(euler_of(in_tdata));
      in_accepts++;
    end
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_accepts != accepts_seen) begin
        accepts_seen = in_accepts;
        busy         = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (quat_queue.size() > 0) begin
          cur_quat = quat_queue.pop_front();
          busy     = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_tvalid <= busy;
      in_tdata  <= cur_quat;
    end
  end

  // receiver: changing stall modes plus long hold-offs that fill the pipeline
  always @(negedge clk) begin
    logic rdy;
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle == 400 || rx_cycle == 1500) hold_left = 200;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: begin
            rdy = 1'b1;
          end
          RX_COIN: begin
            rdy = 1'($urandom_range(0, 1));
          end
          default: begin
            rdy = ($urandom_range(0, 3) == 0);
          end
        endcase
      end
      out_tready <= rdy;
    end
  end

  // output side: compare against the oldest prediction
  always @(posedge clk) begin
    euler_t exp_e, got_e;
    if (rst_n && out_tvalid && out_tready) begin
      got_e = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser};
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected word roll %0d pitch %0d yaw %0d clamp %0b", $time,
                 got_e.roll, got_e.pitch, got_e.yaw, got_e.clamped);
        errors++;
      end else begin
        exp_e = expected_angles.pop_front();
        if (got_e !== exp_e) begin
          $display("%0t: expected roll %0d pitch %0d yaw %0d clamp %0b", $time,
                   exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamped);
          $display("%0t:   actual roll %0d pitch %0d yaw %0d clamp %0b", $time,
                   got_e.roll, got_e.pitch, got_e.yaw, got_e.clamped);
          errors++;
        end
      end
    end
  end

  initial begin
    int  pick;
    bit  timed_out;
    timed_out = 1'b0;
    // directed: zero, identity, half-turns, lock edges, field extremes
    quat_queue.push_back(pack_quat(0, 0, 0, 0));
    quat_queue.push_back(pack_quat(16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(-16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 16384, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 16384, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, 16384));
    quat_queue.push_back(pack_quat(11585, 11585, 0, 0));
    quat_queue.push_back(pack_quat(16384, 0, 0, -1));
    quat_queue.push_back(pack_quat(11585, 0, 11585, 0));
    quat_queue.push_back(pack_quat(11586, 0, 11586, 0));
    quat_queue.push_back(pack_quat(11586, 0, -11586, 0));
    quat_queue.push_back(pack_quat(8192, 0, 16384, 0));
    quat_queue.push_back(pack_quat(8192, 0, -16384, 0));
    quat_queue.push_back(pack_quat(0, 11586, 0, -11586));
    quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(pack_quat(32767, -32768, 32767, -32768));
    quat_queue.push_back(pack_quat(-32768, 32767, -32768, 32767));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) quat_queue.push_back(unit_quat());
      else if (pick < 80) quat_queue.push_back(near_lock());
      else quat_queue.push_back({$urandom, $urandom});
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    fork
      begin
        while (quat_queue.size() != 0 || busy || expected_angles.size() != 0)
          @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && errors == 0 && expected_angles.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
